// ----- src/who_pkg.sv -----
// Package for the wheel and heading odometry block: request types, the sequencer
// state type, fixed-point constants and the constant tables.
// Depends on nothing; used by who_cordic and wheel_heading_odometry.
package who_pkg;

	localparam int CORDIC_STAGES_DEF = 16;

	localparam int ACC_W  = 48;
	localparam int X_W    = 36;
	localparam int Z_W    = 34;
	localparam int DIST_W = 33;
	localparam int QUOT_W = 18;
	localparam int MUL_W  = 33;

	localparam logic [31:0]       CFG_RESET   = 32'd402625;
	localparam logic [DIST_W-1:0] DIST_MAX    = 33'h1_FFFF_FFFF;
	localparam logic [MUL_W-1:0]  KINV_Q30    = 33'd652032875;
	localparam logic [MUL_W-1:0]  HDIV_RECIP  = 33'd11930465;
	localparam int                HDIV_SHIFT  = 29;
	localparam logic [MUL_W-1:0]  HDIV_DIV    = 33'd45;
	localparam logic [15:0]       FRAC_STEP   = 16'd46603;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic signed [31:0] wheel_angle;
		logic signed [23:0] heading;
	} in_item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] x_position;
		logic signed [ACC_W-1:0] y_position;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MDIST,
		ST_MHEAD,
		ST_MX0,
		ST_MA45,
		ST_THETA,
		ST_ROT,
		ST_ACC
	} state_t;

	typedef struct packed {
		logic load;
		logic run;
	} cordic_ctrl_t;

	function automatic logic [29:0] atan_turn(input logic [4:0] idx);
		logic [29:0] val;
		case (idx)
			5'd0:    val = 30'd536870912;
			5'd1:    val = 30'd316933406;
			5'd2:    val = 30'd167458907;
			5'd3:    val = 30'd85004756;
			5'd4:    val = 30'd42667331;
			5'd5:    val = 30'd21354465;
			5'd6:    val = 30'd10679838;
			5'd7:    val = 30'd5340245;
			5'd8:    val = 30'd2670163;
			5'd9:    val = 30'd1335087;
			5'd10:   val = 30'd667544;
			5'd11:   val = 30'd333772;
			5'd12:   val = 30'd166886;
			5'd13:   val = 30'd83443;
			5'd14:   val = 30'd41722;
			5'd15:   val = 30'd20861;
			5'd16:   val = 30'd10430;
			5'd17:   val = 30'd5215;
			5'd18:   val = 30'd2608;
			5'd19:   val = 30'd1304;
			5'd20:   val = 30'd652;
			5'd21:   val = 30'd326;
			5'd22:   val = 30'd163;
			5'd23:   val = 30'd81;
			5'd24:   val = 30'd41;
			5'd25:   val = 30'd20;
			5'd26:   val = 30'd10;
			5'd27:   val = 30'd5;
			5'd28:   val = 30'd3;
			5'd29:   val = 30'd1;
			5'd30:   val = 30'd1;
			default: val = 30'd0;
		endcase
		return val;
	endfunction

	// Rounded remainder part of the heading conversion: the remainder r of the
	// heading over 45 contributes r * 2^21 / 45, rounded to nearest.
	function automatic logic [20:0] heading_frac(input logic [5:0] rem);
		logic [4:0] corr;
		case (rem)
			6'd0, 6'd1:                 corr = 5'd0;
			6'd2, 6'd3:                 corr = 5'd1;
			6'd4, 6'd5, 6'd6:           corr = 5'd2;
			6'd7, 6'd8, 6'd9:           corr = 5'd3;
			6'd10, 6'd11:               corr = 5'd4;
			6'd12, 6'd13, 6'd14:        corr = 5'd5;
			6'd15, 6'd16, 6'd17:        corr = 5'd6;
			6'd18, 6'd19:               corr = 5'd7;
			6'd20, 6'd21, 6'd22:        corr = 5'd8;
			6'd23, 6'd24, 6'd25:        corr = 5'd9;
			6'd26, 6'd27:               corr = 5'd10;
			6'd28, 6'd29, 6'd30:        corr = 5'd11;
			6'd31, 6'd32, 6'd33:        corr = 5'd12;
			6'd34, 6'd35:               corr = 5'd13;
			6'd36, 6'd37, 6'd38:        corr = 5'd14;
			6'd39, 6'd40, 6'd41:        corr = 5'd15;
			6'd42, 6'd43:               corr = 5'd16;
			6'd44:                      corr = 5'd17;
			default:                    corr = 5'd0;
		endcase
		return 21'(22'(rem) * 22'(FRAC_STEP)) + 21'(corr);
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] sum);
		logic signed [ACC_W-1:0] res;
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			res = sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			res = sum[ACC_W-1:0];
		end
		return res;
	endfunction

endpackage

// ----- src/who_cordic.sv -----
// Rotation-mode CORDIC with one shared add, subtract and shift datapath that
// steps through one stage per cycle while run is high, under a stage counter.
// Depends on who_pkg for widths, the control struct and the arctangent table.
module who_cordic #(
	parameter int CORDIC_STAGES = who_pkg::CORDIC_STAGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  who_pkg::cordic_ctrl_t           ctrl,
	input  logic signed [who_pkg::X_W-1:0]  x_init,
	input  logic signed [who_pkg::Z_W-1:0]  z_init,
	output logic signed [who_pkg::X_W-1:0]  x_out,
	output logic signed [who_pkg::X_W-1:0]  y_out,
	output logic                            last
);

	localparam int CNT_W = $clog2(CORDIC_STAGES);

	logic [CNT_W-1:0]               cnt_q;
	logic signed [who_pkg::X_W-1:0] x_q;
	logic signed [who_pkg::X_W-1:0] y_q;
	logic signed [who_pkg::Z_W-1:0] z_q;
	logic signed [who_pkg::X_W-1:0] x_sh;
	logic signed [who_pkg::X_W-1:0] y_sh;
	logic signed [who_pkg::Z_W-1:0] atan_c;

	assign x_sh   = x_q >>> cnt_q;
	assign y_sh   = y_q >>> cnt_q;
	assign atan_c = signed'(who_pkg::Z_W'(who_pkg::atan_turn(5'(cnt_q))));
	assign last   = (cnt_q == CNT_W'(CORDIC_STAGES - 1));
	assign x_out  = x_q;
	assign y_out  = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= '0;
		end else if (ctrl.run) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= x_init;
			y_q <= '0;
			z_q <= z_init;
		end else if (ctrl.run) begin
			if (!z_q[who_pkg::Z_W-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_c;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_c;
			end
		end
	end

endmodule

// ----- src/wheel_heading_odometry.sv -----
// Top level of the single wheel dead-reckoning odometry block: request
// handshakes, configuration register, multiply sequencer and accumulators.
// Depends on who_pkg and who_cordic.
//
//   port group   direction  handshake          payload
//   in_*         into       in_valid/in_ready  who_pkg::in_item_t
//   out_*        out of     out_valid/out_ready who_pkg::out_item_t
//   cfg_*        into       cfg_wr_en          32-bit distance per degree
//
// A primed request goes from acceptance to result through four passes through the
// one 33 by 33 bit multiplier, the angle step, the CORDIC stages and the accumulate
// step. The first request after reset goes straight to the accumulate state. A new
// request is taken only in the idle state; the accumulators form the result
// register, and a finished update waits in the accumulate state while the previous
// result is still held on the output.
module wheel_heading_odometry #(
	parameter int CORDIC_STAGES = who_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  who_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output who_pkg::out_item_t out_data,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data
);

	localparam int HDIV_SHIFT_LO = who_pkg::HDIV_SHIFT;

	who_pkg::state_t state_q;
	who_pkg::state_t state_d;

	logic [31:0]                   cfg_q;
	logic [31:0]                   prev_wheel_q;
	logic                          primed_q;
	logic                          out_valid_q;
	logic signed [who_pkg::ACC_W-1:0] x_acc_q;
	logic signed [who_pkg::ACC_W-1:0] y_acc_q;

	logic                          skip_q;
	logic                          dneg_q;
	logic [31:0]                   dmag_q;
	logic                          hneg_q;
	logic [23:0]                   hmag_q;
	logic [who_pkg::DIST_W-1:0]    dist_q;
	logic [who_pkg::QUOT_W-1:0]    quot_q;
	logic signed [who_pkg::X_W-1:0] x0_q;
	logic                          flip_q;
	logic [2*who_pkg::MUL_W-1:0]   prod_q;

	logic                          accept;
	logic                          acc_load;
	logic [31:0]                   delta_c;
	logic [who_pkg::MUL_W-1:0]     mul_a;
	logic [who_pkg::MUL_W-1:0]     mul_b;
	logic [52:0]                   dist_round;
	logic [who_pkg::DIST_W-1:0]    dist_c;
	logic [33:0]                   x0_round;
	logic [5:0]                    rem_c;
	logic [31:0]                   theta_mag;
	logic [31:0]                   theta_c;
	logic                          flip_c;
	logic [31:0]                   z32_c;
	logic signed [who_pkg::Z_W-1:0] z_init;
	who_pkg::cordic_ctrl_t         cordic_ctrl;
	logic                          cordic_last;
	logic signed [who_pkg::X_W-1:0] cx;
	logic signed [who_pkg::X_W-1:0] cy;
	logic signed [who_pkg::X_W-1:0] dx;
	logic signed [who_pkg::X_W-1:0] dy;
	logic signed [who_pkg::ACC_W:0] x_sum;
	logic signed [who_pkg::ACC_W:0] y_sum;

	assign accept  = in_valid & in_ready;
	assign delta_c = in_data.wheel_angle - prev_wheel_q;

	assign dist_round = 53'((prod_q[63:0] + 64'd2048) >> 12);
	assign dist_c     = (dist_round > 53'(who_pkg::DIST_MAX)) ? who_pkg::DIST_MAX
		: dist_round[who_pkg::DIST_W-1:0];
	assign x0_round   = 34'((prod_q[63:0] + (64'd1 << 29)) >> 30);

	assign rem_c     = 6'(hmag_q - prod_q[23:0]);
	assign theta_mag = {quot_q[10:0], who_pkg::heading_frac(rem_c)};
	assign theta_c   = hneg_q ? (32'd0 - theta_mag) : theta_mag;
	assign flip_c    = theta_c[31] ^ theta_c[30];
	assign z32_c     = {theta_c[31] ^ flip_c, theta_c[30:0]};
	assign z_init    = who_pkg::Z_W'(signed'(z32_c));

	assign dx    = skip_q ? '0 : (flip_q ? -cx : cx);
	assign dy    = skip_q ? '0 : (flip_q ? -cy : cy);
	assign x_sum = (who_pkg::ACC_W+1)'(x_acc_q) + (who_pkg::ACC_W+1)'(dx);
	assign y_sum = (who_pkg::ACC_W+1)'(y_acc_q) + (who_pkg::ACC_W+1)'(dy);

	assign out_valid         = out_valid_q;
	assign out_data.x_position = x_acc_q;
	assign out_data.y_position = y_acc_q;

	who_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cordic_ctrl),
		.x_init (x0_q),
		.z_init (z_init),
		.x_out  (cx),
		.y_out  (cy),
		.last   (cordic_last)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			who_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = primed_q ? who_pkg::ST_MDIST : who_pkg::ST_ACC;
				end
			end
			who_pkg::ST_MDIST: state_d = who_pkg::ST_MHEAD;
			who_pkg::ST_MHEAD: state_d = who_pkg::ST_MX0;
			who_pkg::ST_MX0:   state_d = who_pkg::ST_MA45;
			who_pkg::ST_MA45:  state_d = who_pkg::ST_THETA;
			who_pkg::ST_THETA: state_d = who_pkg::ST_ROT;
			who_pkg::ST_ROT: begin
				if (cordic_last) begin
					state_d = who_pkg::ST_ACC;
				end
			end
			who_pkg::ST_ACC: begin
				if (!out_valid_q || out_ready) begin
					state_d = who_pkg::ST_IDLE;
				end
			end
			default: state_d = who_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = 1'b0;
		acc_load         = 1'b0;
		cordic_ctrl.load = 1'b0;
		cordic_ctrl.run  = 1'b0;
		mul_a            = '0;
		mul_b            = '0;
		case (state_q)
			who_pkg::ST_IDLE: in_ready = 1'b1;
			who_pkg::ST_MDIST: begin
				mul_a = who_pkg::MUL_W'(dmag_q);
				mul_b = who_pkg::MUL_W'(cfg_q);
			end
			who_pkg::ST_MHEAD: begin
				mul_a = who_pkg::MUL_W'(hmag_q);
				mul_b = who_pkg::HDIV_RECIP;
			end
			who_pkg::ST_MX0: begin
				mul_a = dist_q;
				mul_b = who_pkg::KINV_Q30;
			end
			who_pkg::ST_MA45: begin
				mul_a = who_pkg::MUL_W'(quot_q);
				mul_b = who_pkg::HDIV_DIV;
			end
			who_pkg::ST_THETA: cordic_ctrl.load = 1'b1;
			who_pkg::ST_ROT:   cordic_ctrl.run = 1'b1;
			who_pkg::ST_ACC:   acc_load = !out_valid_q || out_ready;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= who_pkg::ST_IDLE;
			cfg_q        <= who_pkg::CFG_RESET;
			prev_wheel_q <= '0;
			primed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			x_acc_q      <= '0;
			y_acc_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (accept) begin
				prev_wheel_q <= in_data.wheel_angle;
				primed_q     <= 1'b1;
			end
			if (acc_load) begin
				x_acc_q     <= who_pkg::sat_acc(x_sum);
				y_acc_q     <= who_pkg::sat_acc(y_sum);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			skip_q <= !primed_q;
			dneg_q <= delta_c[31];
			dmag_q <= delta_c[31] ? (32'd0 - delta_c) : delta_c;
			hneg_q <= in_data.heading[23];
			hmag_q <= in_data.heading[23] ? (24'd0 - in_data.heading) : in_data.heading;
		end
		if (state_q == who_pkg::ST_MHEAD) begin
			dist_q <= dist_c;
		end
		if (state_q == who_pkg::ST_MX0) begin
			quot_q <= prod_q[HDIV_SHIFT_LO +: who_pkg::QUOT_W];
		end
		if (state_q == who_pkg::ST_MA45) begin
			x0_q <= dneg_q ? -who_pkg::X_W'(x0_round) : who_pkg::X_W'(x0_round);
		end
		if (state_q == who_pkg::ST_THETA) begin
			flip_q <= flip_c;
		end
	end

`ifndef SYNTHESIS
	a_prime_only: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !primed_q) |=> (primed_q && skip_q && state_q == who_pkg::ST_ACC))
		else $error("first request after reset did not go straight to accumulate");

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!acc_load |=> ($stable(x_acc_q) && $stable(y_acc_q)))
		else $error("position changed outside an accumulate update");

	a_rot_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == who_pkg::ST_ROT && !cordic_last) |=> (state_q == who_pkg::ST_ROT))
		else $error("rotation left before its last stage");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		acc_load |=> (out_valid_q && state_q == who_pkg::ST_IDLE))
		else $error("accumulate update did not present a result");
`endif

endmodule
